>>> hdl/jpeg_app_segment_stripper_defines.svh
// assertion macros for the jpeg app segment stripper
`ifndef JPEG_APP_SEGMENT_STRIPPER_DEFINES_SVH
`define JPEG_APP_SEGMENT_STRIPPER_DEFINES_SVH

`ifndef SYNTHESIS
`define JASS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define JASS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define JASS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define JASS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> hdl/jass_pkg.sv
// shared types and constants of the jpeg app segment stripper
`default_nettype none

package jass_pkg;

   localparam int unsigned CSR_ADDR_W = 3;

   // register index taken from the byte address (4 bytes per register)
   localparam logic CSR_IDX_STRIP = 1'b0;

   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOS    = 8'hDA;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_EOI    = 8'hD9;
   localparam logic [7:0] STRIP_RESET   = 8'hE1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_TRUNC = 2'd1;
   localparam logic [1:0] STATUS_SHORT = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [1:0] out_count;
      logic [7:0] out_first;
      logic [7:0] out_second;
      logic       out_last;
      logic [1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/jpeg_app_segment_stripper.sv
// top level of the jpeg app segment stripper: csr, parser and output buffering
//
//  channel  direction  transfer rule            payload
//  req      in         req_valid & req_ready    jass_pkg::req_type, one file byte
//  rsp      out        rsp_valid & rsp_ready    jass_pkg::rsp_type, 0 to 2 bytes
//  csr      in         psel&penable&pwrite      strip_marker at byte address 0
//
// one byte per cycle while req_ready is high; the parser state updates in the cycle of the transfer
// and the result goes on rsp through the result register, or through the skid entry on a stall.
// a result register plus one skid entry: req_ready drops only while the skid is full.
// synchronous reset clears the parser, both buffer entries and sets strip_marker to E1.
`default_nettype none
`include "jpeg_app_segment_stripper_defines.svh"

module jpeg_app_segment_stripper (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire jass_pkg::req_type             req_data,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      jass_pkg::rsp_type             rsp_data,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [jass_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output      logic [31:0]                   csr_prdata,
   output      logic                          csr_pready
);

   logic              strip_sel;
   logic [7:0]        strip_ff;
   logic              csr_write;
   logic              accept;
   jass_pkg::rsp_type step_result;

   logic              rsp_valid_ff;
   jass_pkg::rsp_type rsp_data_ff;
   logic              skid_valid_ff;
   jass_pkg::rsp_type skid_data_ff;

   assign strip_sel  = (csr_paddr[2] == jass_pkg::CSR_IDX_STRIP);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = strip_sel ? {24'd0, strip_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= jass_pkg::STRIP_RESET;
      end else if (csr_write && strip_sel) begin
         strip_ff <= csr_pwdata[7:0];
      end
   end

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   jass_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .strip_marker (strip_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept;
            rsp_data_ff  <= step_result;
         end
      end else if (accept) begin
         // result register stalled, park the new result
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `JASS_ASSERT_IMP(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff,
      "skid entry holds a result while the result register is empty")
   `JASS_ASSERT_NXT(a_stall_to_skid, clock, reset, accept && rsp_valid_ff && !rsp_ready,
      skid_valid_ff, "transfer during a stall was not parked")
   `JASS_ASSERT_IMP(a_count_range, clock, reset, rsp_valid_ff,
      rsp_data_ff.out_count != 2'd3, "result byte count out of range")
   `JASS_ASSERT_IMP(a_short_copies_one, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == jass_pkg::STATUS_SHORT,
      rsp_data_ff.out_count == 2'd1, "short length result must carry exactly one byte")

endmodule

`default_nettype wire

>>> hdl/jass_parse.sv
// marker segment parser: per-byte phase tracking and result forming
`default_nettype none

module jass_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire jass_pkg::req_type req_data,
   input  wire logic [7:0]        strip_marker,
   output jass_pkg::rsp_type      result
);

   typedef enum logic [2:0] {
      PH_START0 = 3'd0,
      PH_START1 = 3'd1,
      PH_EXPECT = 3'd2,
      PH_MARKER = 3'd3,
      PH_LENHI  = 3'd4,
      PH_LENLO  = 3'd5,
      PH_BODY   = 3'd6,
      PH_PASS   = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        dropping_ff, dropping_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] bytes_left_ff, bytes_left_in;

   logic [7:0]  b;
   logic [15:0] seg_len;
   logic [15:0] left_dec;
   logic        held;

   assign b       = req_data.in_byte;
   assign seg_len = {length_high_ff, b};

   always_comb begin
      result          = '0;
      result.out_last = req_data.in_last;
      result.status   = jass_pkg::STATUS_OK;
      phase_in        = phase_ff;
      dropping_in     = dropping_ff;
      length_high_in  = length_high_ff;
      bytes_left_in   = bytes_left_ff;
      left_dec        = bytes_left_ff;
      held            = 1'b0;

      case (phase_ff)
         PH_START0: begin
            result.out_first = b;
            result.out_count = 2'd1;
            phase_in         = PH_START1;
         end
         PH_START1: begin
            result.out_first = b;
            result.out_count = 2'd1;
            phase_in         = PH_EXPECT;
         end
         PH_EXPECT: begin
            if (b == jass_pkg::MARKER_PREFIX) begin
               phase_in = PH_MARKER;
            end else begin
               result.out_first = b;
               result.out_count = 2'd1;
               phase_in         = PH_PASS;
            end
         end
         PH_MARKER: begin
            if (b == jass_pkg::MARKER_SOS) begin
               result.out_first  = jass_pkg::MARKER_PREFIX;
               result.out_second = b;
               result.out_count  = 2'd2;
               phase_in          = PH_PASS;
            end else if (b == jass_pkg::MARKER_SOI || b == jass_pkg::MARKER_EOI) begin
               result.out_first  = jass_pkg::MARKER_PREFIX;
               result.out_second = b;
               result.out_count  = 2'd2;
               phase_in          = PH_EXPECT;
            end else if (b == strip_marker) begin
               dropping_in = 1'b1;
               phase_in    = PH_LENHI;
            end else begin
               dropping_in       = 1'b0;
               result.out_first  = jass_pkg::MARKER_PREFIX;
               result.out_second = b;
               result.out_count  = 2'd2;
               phase_in          = PH_LENHI;
            end
         end
         PH_LENHI: begin
            length_high_in = b;
            if (!dropping_ff) begin
               result.out_first = b;
               result.out_count = 2'd1;
            end
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            if (seg_len < 16'd2) begin
               result.status    = jass_pkg::STATUS_SHORT;
               result.out_first = b;
               result.out_count = 2'd1;
               dropping_in      = 1'b0;
               phase_in         = PH_PASS;
            end else begin
               if (!dropping_ff) begin
                  result.out_first = b;
                  result.out_count = 2'd1;
               end
               if (seg_len == 16'd2) begin
                  dropping_in = 1'b0;
                  phase_in    = PH_EXPECT;
               end else begin
                  bytes_left_in = seg_len - 16'd2;
                  phase_in      = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (!dropping_ff) begin
               result.out_first = b;
               result.out_count = 2'd1;
            end
            if (bytes_left_ff != 16'd0) begin
               left_dec = bytes_left_ff - 16'd1;
            end
            bytes_left_in = left_dec;
            if (left_dec == 16'd0) begin
               dropping_in = 1'b0;
               phase_in    = PH_EXPECT;
            end
         end
         PH_PASS: begin
            result.out_first = b;
            result.out_count = 2'd1;
         end
         default: begin
            phase_in = PH_START0;
         end
      endcase

      if (req_data.in_last) begin
         // an ff still held at end of file goes out alone
         held = (phase_in == PH_MARKER);
         if (phase_in inside {PH_MARKER, PH_LENHI, PH_LENLO, PH_BODY} &&
             result.status == jass_pkg::STATUS_OK) begin
            result.status = jass_pkg::STATUS_TRUNC;
         end
         if (held && result.out_count == 2'd0) begin
            result.out_first = jass_pkg::MARKER_PREFIX;
            result.out_count = 2'd1;
         end
         phase_in       = PH_START0;
         dropping_in    = 1'b0;
         length_high_in = 8'd0;
         bytes_left_in  = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START0;
         dropping_ff    <= 1'b0;
         length_high_ff <= 8'd0;
         bytes_left_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         dropping_ff    <= dropping_in;
         length_high_ff <= length_high_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

endmodule

`default_nettype wire
